[src/button_debounce_press_classifier_defines.svh]
// assertion macros for the debounce press classifier top level
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BDPC_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define BDPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/bdpc_pkg.sv]
// types and codes shared by the debounce press classifier
`default_nettype none

package bdpc_pkg;

    // debounced level codes
    typedef enum logic [1:0] {
        LVL_LOW     = 2'd0,
        LVL_HIGH    = 2'd1,
        LVL_FALLING = 2'd2,
        LVL_RISING  = 2'd3
    } level_t;

    // press event codes
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } press_event_t;

    // flank select codes
    localparam logic [1:0] FLANK_NONE    = 2'd0;
    localparam logic [1:0] FLANK_RISING  = 2'd1;
    localparam logic [1:0] FLANK_FALLING = 2'd2;
    localparam logic [1:0] FLANK_BOTH    = 2'd3;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FLANK_SELECT    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_LIMIT      = 2'd2;

    localparam logic [15:0] LONG_LIMIT_RESET = 16'd1000;

    // configuration as seen by the core
    typedef struct packed {
        logic [15:0] sample_interval;
        logic [1:0]  flank_select;
        logic [15:0] long_limit;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [1:0] level_state;
        logic       edge_match;
        logic [1:0] press_event;
        logic       risen_seen;
        logic       fallen_seen;
    } result_t;

endpackage

`default_nettype wire

[src/bdpc_core.sv]
// debounce, sticky flags and press classification for one tick per request
`default_nettype none

module bdpc_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             raw_sample,
    input  wire logic             ack_risen,
    input  wire logic             ack_fallen,
    input  wire bdpc_pkg::cfg_t   cfg,
    output bdpc_pkg::result_t     result
);
    import bdpc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

    logic [TIMER_BITS-1:0] ticks_reg, ticks_next;
    logic                  prev_reg, prev_next;
    logic                  stable_reg, stable_next;
    logic                  risen_reg, risen_next;
    logic                  fallen_reg, fallen_next;
    logic [TIMER_BITS-1:0] press_reg, press_next;
    logic                  long_rep_reg, long_rep_next;
    logic                  short_rep_reg, short_rep_next;

    logic [TIMER_BITS-1:0] ticks_inc;
    logic                  interval_zero;
    logic                  take_sample;
    logic                  agree;
    logic                  level_edge;
    level_t                shown;
    logic                  is_rise;
    logic                  is_fall;
    logic                  risen_out;
    logic                  fallen_out;
    logic                  reached;
    logic                  short_mid;
    logic                  long_mid;
    logic                  short_fire;
    logic                  long_fire;
    logic                  match;
    press_event_t          event_code;

    // sample spacing with a saturating tick counter
    always_comb
    begin
        ticks_inc     = (ticks_reg == TMAX) ? TMAX : ticks_reg + TONE;
        interval_zero = (cfg.sample_interval == '0);
        take_sample   = interval_zero
                        || (CMP_W'(ticks_inc) >= CMP_W'(cfg.sample_interval))
                        || (ticks_inc == TMAX);
        ticks_next    = (take_sample && !interval_zero) ? '0 : ticks_inc;
    end

    // two equal samples that differ from the stable level make an edge
    always_comb
    begin
        agree       = take_sample && (raw_sample == prev_reg);
        level_edge  = agree && (raw_sample != stable_reg);
        stable_next = agree ? raw_sample : stable_reg;
        prev_next   = take_sample ? raw_sample : prev_reg;
        if (level_edge)
        begin
            shown = raw_sample ? LVL_RISING : LVL_FALLING;
        end
        else
        begin
            shown = stable_next ? LVL_HIGH : LVL_LOW;
        end
        is_rise = (shown == LVL_RISING);
        is_fall = (shown == LVL_FALLING);
    end

    // sticky flags report this tick's edge, then take the acknowledge
    always_comb
    begin
        risen_out   = risen_reg  | (level_edge &  raw_sample);
        fallen_out  = fallen_reg | (level_edge & ~raw_sample);
        risen_next  = risen_out  & ~ack_risen;
        fallen_next = fallen_out & ~ack_fallen;
    end

    // flank match
    always_comb
    begin
        case (cfg.flank_select)
            FLANK_RISING:  match = is_rise;
            FLANK_FALLING: match = is_fall;
            FLANK_BOTH:    match = is_rise | is_fall;
            default:       match = 1'b0;
        endcase
    end

    // press timer and short or long press events
    always_comb
    begin
        if (is_fall)
        begin
            press_next = '0;
        end
        else
        begin
            press_next = (press_reg == TMAX) ? TMAX : press_reg + TONE;
        end
        reached = (CMP_W'(press_next) >= CMP_W'(cfg.long_limit)) || (press_next == TMAX);
        short_mid  = is_fall ? 1'b0 : short_rep_reg;
        long_mid   = is_fall ? 1'b0 : long_rep_reg;
        short_fire = is_rise && !short_mid;
        long_fire  = (shown == LVL_LOW) && !long_mid && reached;
        short_rep_next = short_mid | short_fire;
        long_rep_next  = long_mid  | long_fire;
        if (short_fire && !reached)
        begin
            event_code = EV_SHORT;
        end
        else if (long_fire)
        begin
            event_code = EV_LONG;
        end
        else
        begin
            event_code = EV_NONE;
        end
    end

    // result of this tick
    always_comb
    begin
        result.level_state = shown;
        result.edge_match  = match;
        result.press_event = event_code;
        result.risen_seen  = risen_out;
        result.fallen_seen = fallen_out;
    end

    // state registers advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= '0;
            prev_reg      <= 1'b1;
            stable_reg    <= 1'b1;
            risen_reg     <= 1'b1;
            fallen_reg    <= 1'b1;
            press_reg     <= '0;
            long_rep_reg  <= 1'b1;
            short_rep_reg <= 1'b1;
        end
        else if (accept)
        begin
            ticks_reg     <= ticks_next;
            prev_reg      <= prev_next;
            stable_reg    <= stable_next;
            risen_reg     <= risen_next;
            fallen_reg    <= fallen_next;
            press_reg     <= press_next;
            long_rep_reg  <= long_rep_next;
            short_rep_reg <= short_rep_next;
        end
    end

endmodule

`default_nettype wire

[src/button_debounce_press_classifier.sv]
// top level of the switch debouncer with short and long press classification
`default_nettype none
`include "button_debounce_press_classifier_defines.svh"

// Each request is one millisecond tick carrying a raw switch sample and two
// acknowledge bits, and gives exactly one result. The whole tick is worked out
// combinationally from the state registers, so one request is accepted every
// cycle while in_stall is low; results go into a two-entry output buffer, and
// in_stall rises only when both entries hold results that the receiver has not
// yet taken. Configuration writes take effect at the next edge and should be
// made while the block is idle.

module button_debounce_press_classifier #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [bdpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [bdpc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 raw_sample,
    input  wire logic                                 ack_risen,
    input  wire logic                                 ack_fallen,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [1:0]                                level_state,
    output logic                                      edge_match,
    output logic [1:0]                                press_event,
    output logic                                      risen_seen,
    output logic                                      fallen_seen
);
    import bdpc_pkg::*;

    cfg_t       cfg_reg;
    result_t    new_result;
    result_t    head_reg;
    result_t    tail_reg;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    logic       head_we;
    logic       tail_we;

    // configuration registers, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_interval <= '0;
            cfg_reg.flank_select    <= FLANK_NONE;
            cfg_reg.long_limit      <= LONG_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_INTERVAL: cfg_reg.sample_interval <= cfg_data;
                REG_FLANK_SELECT:    cfg_reg.flank_select    <= cfg_data[1:0];
                REG_LONG_LIMIT:      cfg_reg.long_limit      <= cfg_data;
                default:             ;
            endcase
        end
    end

    // per-tick logic
    bdpc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (push),
        .raw_sample (raw_sample),
        .ack_risen  (ack_risen),
        .ack_fallen (ack_fallen),
        .cfg        (cfg_reg),
        .result     (new_result)
    );

    // handshake and buffer control
    always_comb
    begin
        in_stall  = (count_reg == 2'd2);
        out_valid = (count_reg != 2'd0);
        push      = in_valid && !in_stall;
        pop       = out_valid && !out_stall;
        head_we   = ((count_reg == 2'd0) && push)
                    || (pop && ((count_reg == 2'd2) || push));
        tail_we   = push && (count_reg == 2'd1) && !pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // buffer payload
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_reg <= (count_reg == 2'd2) ? tail_reg : new_result;
        end
        if (tail_we)
        begin
            tail_reg <= new_result;
        end
    end

    // result ports
    assign level_state = head_reg.level_state;
    assign edge_match  = head_reg.edge_match;
    assign press_event = head_reg.press_event;
    assign risen_seen  = head_reg.risen_seen;
    assign fallen_seen = head_reg.fallen_seen;

    // consistency checks
    `BDPC_ASSERT_NOW(a_count_bound, 1'b1, count_reg != 2'd3, "buffer count out of range")
    `BDPC_ASSERT_NOW(a_short_on_rise, out_valid && (press_event == EV_SHORT),
        level_state == LVL_RISING, "short press without rising state")
    `BDPC_ASSERT_NOW(a_long_on_low, out_valid && (press_event == EV_LONG),
        level_state == LVL_LOW, "long press without low state")
    `BDPC_ASSERT_NOW(a_match_on_edge, out_valid && edge_match,
        (level_state == LVL_RISING) || (level_state == LVL_FALLING),
        "edge match without an edge")
    `BDPC_ASSERT_NOW(a_rise_sticky, out_valid && (level_state == LVL_RISING),
        risen_seen, "rising state without risen flag")

endmodule

`default_nettype wire
